// ----- rtl/utf8vc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, byte constants and decode functions for the UTF-8 validator.
// No dependencies.
package utf8vc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned OUT_BITS       = 32;

  // Lead and continuation byte limits
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_EF   = 8'hEF;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] BYTE_A0   = 8'hA0;
  localparam logic [7:0] BYTE_9F   = 8'h9F;
  localparam logic [7:0] BYTE_90   = 8'h90;
  localparam logic [7:0] BYTE_8F   = 8'h8F;
  localparam logic [7:0] BYTE_AF   = 8'hAF;
  localparam logic [7:0] BYTE_B7   = 8'hB7;
  localparam logic [7:0] BYTE_BE   = 8'hBE;
  localparam logic [7:0] BYTE_BF   = 8'hBF;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;
  localparam logic [2:0] LEN_5 = 3'd5;
  localparam logic [2:0] LEN_6 = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } utf8vc_in_t;

  typedef struct packed {
    logic                valid_res;
    logic [OUT_BITS-1:0] char_count;
    logic [OUT_BITS-1:0] end_offset;
  } utf8vc_out_t;

  // Sequence length implied by a lead byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'hC0)      len = LEN_1;
    else if (b < 8'hE0) len = LEN_2;
    else if (b < 8'hF0) len = LEN_3;
    else if (b < 8'hF8) len = LEN_4;
    else if (b < 8'hFC) len = LEN_5;
    else if (b < 8'hFE) len = LEN_6;
    else                len = LEN_1;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= CONT_MIN) && (b <= CONT_MAX);
  endfunction

endpackage

// ----- rtl/utf8vc_seq_check.sv -----
`timescale 1ns / 1ps
// Verdict on one completed UTF-8 sequence (length, held bytes, final byte).
// Depends on utf8vc_pkg.
module utf8vc_seq_check (
  input  logic [2:0]  len_i,
  input  logic [23:0] held_i,
  input  logic [7:0]  fin_i,
  output logic        ok_o
);
  import utf8vc_pkg::*;

  logic [7:0] h2, h1, h0;

  assign h2 = held_i[23:16];
  assign h1 = held_i[15:8];
  assign h0 = held_i[7:0];

  always_comb begin
    ok_o = 1'b0;
    case (len_i)
      LEN_1: ok_o = fin_i < CONT_MIN;
      LEN_2: ok_o = (h0 >= LEAD2_MIN) && is_cont(fin_i);
      LEN_3: begin
        // h1 = lead, h0 = second byte
        ok_o = is_cont(h0) && is_cont(fin_i);
        if (h1 == LEAD_E0 && h0 < BYTE_A0) ok_o = 1'b0;
        if (h1 == LEAD_ED && h0 > BYTE_9F) ok_o = 1'b0;
        if (h1 == LEAD_EF) begin
          // noncharacters FDD0..FDEF and FFFE/FFFF
          if (h0 == BYTE_B7 && fin_i >= BYTE_90 && fin_i <= BYTE_AF) ok_o = 1'b0;
          if (h0 == BYTE_BF && (fin_i == BYTE_BE || fin_i == BYTE_BF)) ok_o = 1'b0;
        end
      end
      LEN_4: begin
        ok_o = (h2 <= LEAD_F4) && is_cont(h1) && is_cont(h0) && is_cont(fin_i);
        if (h2 == LEAD_F0 && h1 < BYTE_90) ok_o = 1'b0;
        if (h2 == LEAD_F4 && h1 > BYTE_8F) ok_o = 1'b0;
        if ((fin_i == BYTE_BE || fin_i == BYTE_BF) && h0 == BYTE_BF && h1[3:0] == 4'hF)
          ok_o = 1'b0;
      end
      default: ok_o = 1'b0;
    endcase
  end

endmodule

// ----- rtl/utf8vc_core.sv -----
`timescale 1ns / 1ps
// Sequence walker state, counters and result register.
// Depends on utf8vc_pkg and utf8vc_seq_check.
module utf8vc_core #(
  parameter int unsigned COUNT_BITS = utf8vc_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  utf8vc_pkg::utf8vc_in_t   item_i,
  output logic                     item_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output utf8vc_pkg::utf8vc_out_t  out_data_o
);
  import utf8vc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [2:0]            bytes_left_q, bytes_left_d;
  logic [23:0]           seq_bytes_q, seq_bytes_d;
  logic [2:0]            seq_length_q, seq_length_d;
  logic [COUNT_BITS-1:0] seq_start_q, seq_start_d;
  logic [COUNT_BITS-1:0] byte_offset_q, byte_offset_d;
  logic [COUNT_BITS-1:0] seq_count_q, seq_count_d;
  logic                  all_valid_q, all_valid_d;
  logic [COUNT_BITS-1:0] first_bad_q, first_bad_d;
  logic                  out_valid_q;
  utf8vc_out_t           out_data_q;

  logic        advance;
  logic        starting;
  logic [23:0] held;
  logic        seq_done;
  logic        seq_ok;
  logic        bad;

  assign item_ready_o = !out_valid_q || !out_stall_i;
  assign advance      = item_valid_i && item_ready_o;
  assign starting     = (bytes_left_q == 3'd0);
  assign held         = starting ? 24'd0 : seq_bytes_q;

  always_comb begin
    seq_length_d  = starting ? lead_len(item_i.data_byte) : seq_length_q;
    bytes_left_d  = starting ? seq_length_d - 3'd1 : bytes_left_q - 3'd1;
    seq_start_d   = starting ? byte_offset_q : seq_start_q;
    seq_count_d   = (starting && seq_count_q != CNT_MAX) ? seq_count_q + 1'b1 : seq_count_q;
    byte_offset_d = (byte_offset_q != CNT_MAX) ? byte_offset_q + 1'b1 : byte_offset_q;
    seq_done      = (bytes_left_d == 3'd0);
    seq_bytes_d   = seq_done ? held : {held[15:0], item_i.data_byte};
    // truncated sequence at end of string is bad too
    bad           = (seq_done && !seq_ok) || (item_i.last && !seq_done);
    all_valid_d   = all_valid_q && !bad;
    first_bad_d   = (all_valid_q && bad) ? seq_start_d : first_bad_q;
  end

  utf8vc_seq_check u_seq_check (
    .len_i  (seq_length_d),
    .held_i (held),
    .fin_i  (item_i.data_byte),
    .ok_o   (seq_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q  <= '0;
      seq_bytes_q   <= '0;
      seq_length_q  <= '0;
      seq_start_q   <= '0;
      byte_offset_q <= '0;
      seq_count_q   <= '0;
      all_valid_q   <= 1'b1;
      first_bad_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        if (item_i.last) begin
          bytes_left_q  <= '0;
          seq_bytes_q   <= '0;
          seq_length_q  <= '0;
          seq_start_q   <= '0;
          byte_offset_q <= '0;
          seq_count_q   <= '0;
          all_valid_q   <= 1'b1;
          first_bad_q   <= '0;
        end else begin
          bytes_left_q  <= bytes_left_d;
          seq_bytes_q   <= seq_bytes_d;
          seq_length_q  <= seq_length_d;
          seq_start_q   <= seq_start_d;
          byte_offset_q <= byte_offset_d;
          seq_count_q   <= seq_count_d;
          all_valid_q   <= all_valid_d;
          first_bad_q   <= first_bad_d;
        end
      end
      if (advance && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (advance && item_i.last) begin
      out_data_q.valid_res  <= all_valid_d;
      out_data_q.char_count <= OUT_BITS'(seq_count_d);
      out_data_q.end_offset <= all_valid_d ? OUT_BITS'(byte_offset_d)
                                           : OUT_BITS'(first_bad_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= 3'd5)
    else $error("bytes_left out of range");

  a_left_vs_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q != 3'd0 |-> seq_length_q > bytes_left_q)
    else $error("bytes_left not below sequence length");

  a_count_le_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_count_q <= byte_offset_q)
    else $error("sequence count exceeds byte offset");

  a_bad_le_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !all_valid_q |-> first_bad_q <= byte_offset_q)
    else $error("first bad offset beyond bytes consumed");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_i.last |=> bytes_left_q == 3'd0 && all_valid_q && out_valid_q)
    else $error("end of string did not restart walker");

endmodule

// ----- rtl/utf8_validate_and_count_top.sv -----
`timescale 1ns / 1ps
// Top level of the strict UTF-8 validator and sequence counter.
// Depends on utf8vc_pkg and utf8vc_core.
//
// Usage:
//   Input channel: one string byte per transaction (data_byte, last), with
//   in_valid_i / in_stall_o. Bytes of one string follow in order; the byte
//   with last set closes the string and the next byte starts a new one.
//   Output channel: one transaction per string, out_valid_o / out_stall_i,
//   carrying valid_res, char_count (sequences walked, invalid ones too) and
//   end_offset (first bad sequence start, or byte length when valid).
//   Counters are COUNT_BITS wide, saturate, and are reported in 32 bits.
// Result: out_valid_o rises once the last byte has passed the input register
//   and the walker has written the result register.
// Throughput: one byte per cycle with no stalled result, set by the single
//   walker stage whose state update must finish before the next byte is judged.
// Stall: a held result blocks the walker only; an empty input register still
//   takes one more byte, then in_stall_o rises until the result is taken.
// Reset: asynchronous, active low; clears the walker to the start of a new
//   string and drops both valid flags.
module utf8_validate_and_count_top #(
  parameter int unsigned COUNT_BITS = utf8vc_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  utf8vc_pkg::utf8vc_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output utf8vc_pkg::utf8vc_out_t  out_data_o
);
  import utf8vc_pkg::*;

  logic       in_valid_q;
  utf8vc_in_t in_data_q;
  logic       core_ready;
  logic       in_take;

  // input register frees when empty or when the walker consumes it
  assign in_stall_o = in_valid_q && !core_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  utf8vc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_data_q),
    .item_ready_o (core_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result path free");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted byte not held in input register");

endmodule
